// ----- design/strc_pkg.sv -----
// shared types and constants for the subtree revocation cover block
package strc_pkg;

    localparam int DEF_MAX_DEVICES = 64;
    localparam int MAX_RESULTS     = 64;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int DEV_COUNT_W     = 7;
    localparam int LABEL_W         = 7;
    localparam int KEY_W           = 7;
    localparam int COVER_W         = 7;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam logic [DEV_COUNT_W-1:0] DEV_COUNT_RESET = 7'd64;

    // register index bit of the configuration address (byte address 4*i)
    localparam logic CFG_IDX_DEVICE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_REVOKE = 2'd1,
        OP_COVER  = 2'd2,
        OP_MATCH  = 2'd3
    } strc_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NOT_DEV = 2'd2
    } strc_status_t;

    typedef struct packed {
        strc_op_t            opcode;
        logic [LABEL_W-1:0]  device_label;
        logic [KEY_W-1:0]    key_id;
        logic                list_start;
    } strc_cmd_t;

    typedef struct packed {
        strc_status_t        status;
        logic [COVER_W-1:0]  cover_node;
        logic                is_match;
        logic                first_match_res;
        logic                last;
    } strc_rsp_t;

endpackage

// ----- design/subtree_revocation_cover.sv -----
// subtree revocation cover: revoked marks over a heap-indexed device tree, cover and match
//
// One command beat is taken at a time; cmd_stall stays high until its last
// result beat, if any, is loaded into the output register. The revoked marks
// live in a single-port memory of 2*MAX_DEVICES bits; a small sequencer does
// at most one read or one write of it per cycle. After reset, and for every
// clear command, all marks are swept to zero one entry a cycle, during which
// commands are not taken but configuration writes are. Revoke marks the device
// node and each ancestor up to the root, one node a cycle; match walks the same
// path, shifting the device node right and comparing it with the key. A cover
// request gives an unrevoked root alone, else each unrevoked child of a revoked parent
// below N, up to MAX_RESULTS beats. device_count is written through the APB port at
// byte address 0; the user must write it only while idle: the block does not enforce it.
module subtree_revocation_cover
    import strc_pkg::*;
#(
    parameter int MAX_DEVICES = DEF_MAX_DEVICES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  strc_cmd_t             cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output strc_rsp_t             rsp
);

    localparam int NODE_SLOTS = 2 * MAX_DEVICES;
    localparam int NODE_W     = (NODE_SLOTS > 2) ? $clog2(NODE_SLOTS) : 1;
    localparam int SIZE_W     = $clog2(NODE_SLOTS + 1);
    localparam int CW         = (SIZE_W > LABEL_W) ? SIZE_W : LABEL_W;
    localparam logic [NODE_W-1:0] LAST_SLOT = NODE_W'(NODE_SLOTS - 1);
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DONE,
        S_REVOKE,
        S_MATCH,
        S_ROOT,
        S_PAR,
        S_LEFT,
        S_RIGHT,
        S_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic                   clr_op_reg, clr_op_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   hit_reg, hit_next;
    logic                   found_reg, found_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0]      pend_node_reg, pend_node_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    strc_rsp_t              res_reg, res_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    strc_rsp_t              rsp_reg, rsp_next;
    logic [DEV_COUNT_W-1:0] dev_count_reg;

    logic                   mark_mem [NODE_SLOTS];
    logic                   rd_data_reg;
    logic                   rd_en;
    logic [NODE_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [NODE_W-1:0]      wr_addr;
    logic                   wr_bit;

    logic [CW-1:0]          n_eff;
    logic [CW-1:0]          size_w;
    logic [CW-1:0]          label_w;
    logic [CW-1:0]          lab_node_w;
    strc_status_t           lab_st;
    logic [NODE_W-1:0]      lab_node;
    logic                   out_free;
    logic [NODE_W-1:0]      child_l;
    logic [NODE_W-1:0]      child_r;
    logic [NODE_W-1:0]      node_inc;
    logic                   more_par;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   cap_hit;
    logic                   hit_now;
    logic                   cfg_wr;

    function automatic strc_rsp_t status_beat(input strc_status_t st, input logic m,
                                              input logic f);
        strc_rsp_t b;
        begin
            b.status          = st;
            b.cover_node      = '0;
            b.is_match        = m;
            b.first_match_res = f;
            b.last            = 1'b1;
            return b;
        end
    endfunction

    function automatic strc_rsp_t cover_beat(input logic [NODE_W-1:0] nd, input logic lst);
        strc_rsp_t     b;
        logic [CW-1:0] wide;
        begin
            wide              = CW'(nd);
            b.status          = ST_OK;
            b.cover_node      = wide[COVER_W-1:0];
            b.is_match        = 1'b0;
            b.first_match_res = 1'b0;
            b.last            = lst;
            return b;
        end
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_DEVICE_COUNT);
    assign prdata = (paddr[2] == CFG_IDX_DEVICE_COUNT)
                  ? CFG_DATA_W'(dev_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_count_reg <= DEV_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            dev_count_reg <= pwdata[DEV_COUNT_W-1:0];
        end
    end

    // mark memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mark_mem[rd_addr];
        end
    end

    // label decode
    always_comb
    begin
        if (dev_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (CW'(dev_count_reg) > CW'(MAX_DEVICES))
        begin
            n_eff = CW'(MAX_DEVICES);
        end
        else
        begin
            n_eff = CW'(dev_count_reg);
        end
    end

    assign size_w     = n_eff << 1;
    assign label_w    = CW'(cmd.device_label);
    assign lab_node_w = size_w - label_w;
    assign lab_node   = lab_node_w[NODE_W-1:0];

    always_comb
    begin
        if (label_w == '0 || label_w >= size_w)
        begin
            lab_st = ST_RANGE;
        end
        else if (lab_node_w < n_eff)
        begin
            lab_st = ST_NOT_DEV;
        end
        else
        begin
            lab_st = ST_OK;
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign child_l   = node_reg << 1;
    assign child_r   = child_l | NODE_W'(1);
    assign node_inc  = node_reg + NODE_W'(1);
    assign more_par  = (CW'(node_reg) + CW'(1)) < n_eff;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign cap_hit   = (cnt_inc == CNT_W'(MAX_RESULTS));
    assign hit_now   = hit_reg || (CW'(node_reg) == CW'(key_reg));
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_op_next     = clr_op_reg;
        node_next       = node_reg;
        key_next        = key_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        rd_en           = 1'b0;
        rd_addr         = node_reg;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_bit          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (node_reg == LAST_SLOT)
                begin
                    node_next = '0;
                    if (clr_op_reg)
                    begin
                        res_next   = status_beat(ST_OK, 1'b0, 1'b0);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    node_next = node_inc;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next = cmd.key_id;
                    case (cmd.opcode)
                        OP_CLEAR:
                        begin
                            clr_op_next = 1'b1;
                            node_next   = '0;
                            state_next  = S_CLEAR;
                        end
                        OP_REVOKE:
                        begin
                            if (lab_st != ST_OK)
                            begin
                                res_next   = status_beat(lab_st, 1'b0, 1'b0);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                node_next  = lab_node;
                                state_next = S_REVOKE;
                            end
                        end
                        OP_COVER:
                        begin
                            rd_en           = 1'b1;
                            rd_addr         = ROOT;
                            cnt_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_ROOT;
                        end
                        OP_MATCH:
                        begin
                            if (cmd.list_start)
                            begin
                                found_next = 1'b0;
                            end
                            if (lab_st != ST_OK)
                            begin
                                res_next   = status_beat(lab_st, 1'b0, 1'b0);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                node_next  = lab_node;
                                hit_next   = 1'b0;
                                state_next = S_MATCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REVOKE:
            begin
                wr_en     = 1'b1;
                wr_bit    = 1'b1;
                node_next = node_reg >> 1;
                if ((node_reg >> 1) == '0)
                begin
                    res_next   = status_beat(ST_OK, 1'b0, 1'b0);
                    state_next = S_DONE;
                end
            end
            S_MATCH:
            begin
                hit_next  = hit_now;
                node_next = node_reg >> 1;
                if ((node_reg >> 1) == '0)
                begin
                    res_next   = status_beat(ST_OK, hit_now, hit_now && !found_reg);
                    found_next = found_reg || hit_now;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    clr_op_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (!rd_data_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_node_next  = ROOT;
                    state_next      = S_FLUSH;
                end
                else if (CW'(1) < n_eff)
                begin
                    node_next  = ROOT;
                    rd_en      = 1'b1;
                    rd_addr    = ROOT;
                    state_next = S_PAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAR:
            begin
                if (rd_data_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = child_l;
                    state_next = S_LEFT;
                end
                else if (more_par)
                begin
                    node_next = node_inc;
                    rd_en     = 1'b1;
                    rd_addr   = node_inc;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_LEFT:
            begin
                if (rd_data_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = child_r;
                    state_next = S_RIGHT;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = cover_beat(pend_node_reg, 1'b0);
                    end
                    pend_valid_next = 1'b1;
                    pend_node_next  = child_l;
                    cnt_next        = cnt_inc;
                    if (cap_hit)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = child_r;
                        state_next = S_RIGHT;
                    end
                end
            end
            S_RIGHT:
            begin
                if (rd_data_reg || !pend_valid_reg || out_free)
                begin
                    if (!rd_data_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = cover_beat(pend_node_reg, 1'b0);
                        end
                        pend_valid_next = 1'b1;
                        pend_node_next  = child_r;
                        cnt_next        = cnt_inc;
                    end
                    if (!rd_data_reg && cap_hit)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (more_par)
                    begin
                        node_next  = node_inc;
                        rd_en      = 1'b1;
                        rd_addr    = node_inc;
                        state_next = S_PAR;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = cover_beat(pend_node_reg, 1'b1);
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_op_reg     <= 1'b0;
            node_reg       <= '0;
            key_reg        <= '0;
            hit_reg        <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_node_reg  <= '0;
            cnt_reg        <= '0;
            res_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_op_reg     <= clr_op_next;
            node_reg       <= node_next;
            key_reg        <= key_next;
            hit_reg        <= hit_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            pend_node_reg  <= pend_node_next;
            cnt_reg        <= cnt_next;
            res_reg        <= res_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

endmodule

// ----- test/subtree_revocation_cover_tb.sv -----
// testbench for subtree_revocation_cover: directed and random commands checked against a tree model
module subtree_revocation_cover_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import strc_pkg::*;

    localparam int TREE_SLOTS  = 2 * DEF_MAX_DEVICES;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 300;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_ADDR_W-1:0] DEVICE_COUNT_ADDR = {CFG_IDX_DEVICE_COUNT, 2'b00};

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    class revocation_board;
        strc_rsp_t              pending_rsp[$];
        bit                     marks[TREE_SLOTS];
        bit                     found;
        logic [DEV_COUNT_W-1:0] dev_count;
        int                     errors;
        int                     beats;
        int                     empty_covers;
        int                     op_seen[4];

        function void reset_state();
            foreach (marks[i])
                marks[i] = 1'b0;
            found     = 1'b0;
            dev_count = DEV_COUNT_RESET;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void queue_beat(strc_rsp_t r);
            pending_rsp = {pending_rsp, r};
        endfunction

        function int tree_leaves();
            if (dev_count == 0)
                return 1;
            if (dev_count > DEF_MAX_DEVICES)
                return DEF_MAX_DEVICES;
            return int'(dev_count);
        endfunction

        function strc_status_t label_node(input logic [LABEL_W-1:0] label, input int n,
                                          output int node);
            node = 0;
            if (label == 0 || int'(label) >= 2 * n)
                return ST_RANGE;
            node = 2 * n - int'(label);
            if (node < n)
                return ST_NOT_DEV;
            return ST_OK;
        endfunction

        function strc_rsp_t beat_of(strc_status_t st, int node, bit m, bit f, bit lst);
            strc_rsp_t r;
            r.status          = st;
            r.cover_node      = COVER_W'(node);
            r.is_match        = m;
            r.first_match_res = f;
            r.last            = lst;
            return r;
        endfunction

        function string show(strc_rsp_t r);
            return $sformatf("status=%0d node=%0d match=%0b first=%0b last=%0b",
                             r.status, r.cover_node, r.is_match, r.first_match_res, r.last);
        endfunction

        function void predict_cover(int n);
            strc_rsp_t run[$];
            strc_rsp_t r;
            bit        any;
            int        c;
            any = 1'b0;
            for (int i = 1; i < 2 * n; i++)
                if (marks[i])
                    any = 1'b1;
            if (!any)
            begin
                queue_beat(beat_of(ST_OK, 1, 1'b0, 1'b0, 1'b1));
                return;
            end
            for (int i = 1; i < 2 * n && run.size() < MAX_RESULTS; i++)
            begin
                c = 2 * i;
                if (marks[i] && c < 2 * n)
                begin
                    if (!marks[c])
                        run = {run, beat_of(ST_OK, c, 1'b0, 1'b0, 1'b0)};
                    if (!marks[c + 1] && run.size() < MAX_RESULTS)
                        run = {run, beat_of(ST_OK, c + 1, 1'b0, 1'b0, 1'b0)};
                end
            end
            if (run.size() == 0)
                empty_covers++;
            foreach (run[k])
            begin
                r      = run[k];
                r.last = (k == run.size() - 1);
                queue_beat(r);
            end
        endfunction

        function void predict_match(strc_cmd_t c, int n);
            int           node;
            strc_status_t st;
            bit           hit;
            if (c.list_start)
                found = 1'b0;
            st = label_node(c.device_label, n, node);
            if (st != ST_OK)
            begin
                queue_beat(beat_of(st, 0, 1'b0, 1'b0, 1'b1));
                return;
            end
            hit = 1'b0;
            while (node > 0)
            begin
                if (node == int'(c.key_id))
                    hit = 1'b1;
                node = node >> 1;
            end
            queue_beat(beat_of(ST_OK, 0, hit, hit && !found, 1'b1));
            if (hit)
                found = 1'b1;
        endfunction

        function void note_command(strc_cmd_t c);
            int           n;
            int           node;
            strc_status_t st;
            n = tree_leaves();
            op_seen[int'(c.opcode)]++;
            case (c.opcode)
                OP_CLEAR:
                begin
                    foreach (marks[i])
                        marks[i] = 1'b0;
                    queue_beat(beat_of(ST_OK, 0, 1'b0, 1'b0, 1'b1));
                end
                OP_REVOKE:
                begin
                    st = label_node(c.device_label, n, node);
                    if (st == ST_OK)
                        while (node > 0)
                        begin
                            marks[node] = 1'b1;
                            node = node >> 1;
                        end
                    queue_beat(beat_of(st, 0, 1'b0, 1'b0, 1'b1));
                end
                OP_COVER:
                    predict_cover(n);
                default:
                    predict_match(c, n);
            endcase
        endfunction

        function void check_response(strc_rsp_t got);
            strc_rsp_t want;
            beats++;
            if (pending_rsp.size() == 0)
            begin
                flag($sformatf("beat %0d not expected: %s", beats, show(got)));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.cover_node !== want.cover_node ||
                got.is_match !== want.is_match ||
                got.first_match_res !== want.first_match_res || got.last !== want.last)
                flag($sformatf("beat %0d expected %s got %s", beats, show(want), show(got)));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  cmd_valid;
    logic                  cmd_stall;
    strc_cmd_t             cmd;
    logic                  rsp_valid;
    logic                  rsp_stall;
    strc_rsp_t             rsp;

    revocation_board board;
    idle_mode_t      idle_mode = IDLE_NONE;
    bit              hold_req  = 1'b0;
    int              cycles    = 0;

    subtree_revocation_cover dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    function automatic bit roll_send_idle();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99, 0) < 70;
            IDLE_BOTH: return $urandom_range(99, 0) < 8;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit roll_recv_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99, 0) < 70;
            IDLE_BOTH: return $urandom_range(99, 0) < 8;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic strc_cmd_t make_cmd(strc_op_t op, int label, int key, bit start);
        strc_cmd_t c;
        c.opcode       = op;
        c.device_label = LABEL_W'(label);
        c.key_id       = KEY_W'(key);
        c.list_start   = start;
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] cfg_word(int count);
        return ($urandom() & ~32'h7f) | CFG_DATA_W'(count & 'h7f);
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label(int n);
        if ($urandom_range(99, 0) < 85)
            return LABEL_W'($urandom_range(n, 1));
        return LABEL_W'($urandom_range((1 << LABEL_W) - 1, 0));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(logic [LABEL_W-1:0] label, int n);
        int node;
        node = 2 * n - int'(label);
        if (label != 0 && node >= n && node < 2 * n && $urandom_range(99, 0) < 60)
            return KEY_W'(node >> $urandom_range(6, 0));
        return KEY_W'($urandom_range((1 << KEY_W) - 1, 0));
    endfunction

    // response side: check accepted beats, random stall, long hold-off on request
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_response(rsp);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_stall <= roll_recv_stall();
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("subtree_revocation_cover_tb: errors");
        $finish;
    end

    task automatic send_cmd(input strc_cmd_t c);
        while (roll_send_idle())
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(c);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        while (board.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_device_count(input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DEVICE_COUNT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.dev_count = value[DEV_COUNT_W-1:0];
        // back-to-back read of the same register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== CFG_DATA_W'(value[DEV_COUNT_W-1:0]))
            board.flag($sformatf("device_count read %0d after writing %0d",
                                 got, value[DEV_COUNT_W-1:0]));
    endtask

    task automatic run_random(input int items);
        int                   left;
        int                   n;
        int                   roll;
        int                   burst;
        logic [LABEL_W-1:0]   label;
        left = items;
        n    = board.tree_leaves();
        while (left > 0)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 6)
            begin
                send_cmd(make_cmd(OP_CLEAR, $urandom_range(127, 0), $urandom_range(127, 0),
                                  1'($urandom_range(1, 0))));
                left--;
            end
            else if (roll < 38)
            begin
                send_cmd(make_cmd(OP_REVOKE, int'(pick_label(n)), $urandom_range(127, 0),
                                  1'($urandom_range(1, 0))));
                left--;
            end
            else if (roll < 56)
            begin
                send_cmd(make_cmd(OP_COVER, $urandom_range(127, 0), $urandom_range(127, 0),
                                  1'($urandom_range(1, 0))));
                left--;
            end
            else
            begin
                // one header: usually a list start, then up to four more key entries for the same device
                burst = $urandom_range(5, 1);
                label = pick_label(n);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    send_cmd(make_cmd(OP_MATCH, int'(label), int'(pick_key(label, n)),
                                      k == 0 ? ($urandom_range(9, 0) != 0)
                                             : ($urandom_range(9, 0) == 0)));
                    left--;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] word, input idle_mode_t mode,
                             input int items, input bit press);
        write_device_count(word);
        idle_mode = mode;
        if (press)
            hold_req = 1'b1;
        run_random(items);
        settle();
    endtask

    initial
    begin
        board = new();
        board.reset_state();
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // four devices: empty tree, match corner cases, bad labels, full revocation
        write_device_count(cfg_word(4));
        send_cmd(make_cmd(OP_COVER, 0, 0, 1'b0));
        send_cmd(make_cmd(OP_MATCH, 1, 7, 1'b1));
        send_cmd(make_cmd(OP_MATCH, 1, 3, 1'b0));
        send_cmd(make_cmd(OP_MATCH, 1, 0, 1'b0));
        send_cmd(make_cmd(OP_MATCH, 0, 127, 1'b1));
        send_cmd(make_cmd(OP_MATCH, 127, 1, 1'b0));
        send_cmd(make_cmd(OP_MATCH, 5, 1, 1'b0));
        send_cmd(make_cmd(OP_REVOKE, 0, 0, 1'b0));
        send_cmd(make_cmd(OP_REVOKE, 7, 0, 1'b0));
        send_cmd(make_cmd(OP_REVOKE, 4, 0, 1'b0));
        send_cmd(make_cmd(OP_REVOKE, 1, 0, 1'b0));
        send_cmd(make_cmd(OP_COVER, 127, 127, 1'b1));
        send_cmd(make_cmd(OP_MATCH, 2, 127, 1'b1));
        send_cmd(make_cmd(OP_REVOKE, 2, 0, 1'b0));
        send_cmd(make_cmd(OP_REVOKE, 3, 0, 1'b0));
        send_cmd(make_cmd(OP_COVER, 0, 0, 1'b0));
        send_cmd(make_cmd(OP_CLEAR, 127, 127, 1'b1));
        send_cmd(make_cmd(OP_COVER, 0, 0, 1'b0));
        settle();

        // zero devices saturates to a single-node tree
        write_device_count(cfg_word(0));
        send_cmd(make_cmd(OP_REVOKE, 1, 0, 1'b0));
        send_cmd(make_cmd(OP_COVER, 0, 0, 1'b0));
        send_cmd(make_cmd(OP_MATCH, 1, 1, 1'b1));
        send_cmd(make_cmd(OP_REVOKE, 2, 0, 1'b0));
        settle();

        // oversized count saturates; then stale marks above a smaller tree
        write_device_count(cfg_word(127));
        send_cmd(make_cmd(OP_REVOKE, 64, 0, 1'b0));
        send_cmd(make_cmd(OP_MATCH, 1, 127, 1'b1));
        send_cmd(make_cmd(OP_COVER, 0, 0, 1'b0));
        settle();
        write_device_count(cfg_word(4));
        send_cmd(make_cmd(OP_COVER, 0, 0, 1'b0));
        settle();

        run_phase(cfg_word(64), IDLE_NONE, 40, 1'b0);
        run_phase(cfg_word(1), IDLE_SEND, 25, 1'b0);
        run_phase(cfg_word(2), IDLE_RECV, 30, 1'b0);
        run_phase(cfg_word($urandom_range(63, 3)), IDLE_BOTH, 40, 1'b0);
        run_phase(cfg_word(127), IDLE_NONE, 40, 1'b1);
        run_phase(cfg_word(0), IDLE_RECV, 20, 1'b0);
        run_phase(cfg_word($urandom_range(20, 5)), IDLE_SEND, 40, 1'b0);
        run_phase(cfg_word(64), IDLE_BOTH, 45, 1'b0);
        run_phase(cfg_word($urandom_range(127, 0)), IDLE_NONE, 40, 1'b0);

        $display("commands: %0d clear, %0d revoke, %0d cover (%0d with no entries), %0d match",
                 board.op_seen[OP_CLEAR], board.op_seen[OP_REVOKE], board.op_seen[OP_COVER],
                 board.empty_covers, board.op_seen[OP_MATCH]);
        $display("%0d response beats checked; device counts 0, 1, 2, 4, 64, 127 and random, %s",
                 board.beats, "with send gaps, response stalls and a long hold-off");
        if (board.errors == 0)
            $display("subtree_revocation_cover_tb: clean");
        else
            $display("subtree_revocation_cover_tb: errors");
        $finish;
    end

endmodule
